/* rtl/core/rgc_pkg.sv */
// ----------------------------------------------------------------------------
// rgc_pkg
// Shared types, widths and helpers for the readability grade counter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgc_pkg;

	// counter width (8 to 24)
	localparam int COUNT_WIDTH = 16;

	// product of a 12-bit weight and a word count (COUNT_WIDTH+1 bits)
	localparam int PROD_W = COUNT_WIDTH + 13;
	// signed numerator 588*L - 2960*S - 1580*W
	localparam int NUM_W  = COUNT_WIDTH + 16;
	// rounding dividend 2*|num| + 100*W, also the quotient width
	localparam int DVD_W  = NUM_W + 1;
	// divisor 200*W
	localparam int DVS_W  = COUNT_WIDTH + 9;
	localparam int DCNT_W = $clog2(DVD_W);

	localparam int K_LETTER = 588;
	localparam int K_STOP   = 2960;
	localparam int K_WORD   = 1580;
	localparam int K_DEN2   = 200;

	localparam int IDX_W   = 22;
	localparam int IDX_POS = 2**(IDX_W-1) - 1;
	localparam int IDX_NEG = 2**(IDX_W-1);
	localparam int GN_W    = 5;
	localparam int GRADE_TOP = 16;

	localparam logic [1:0] CLS_BELOW = 2'd0;
	localparam logic [1:0] CLS_NUM   = 2'd1;
	localparam logic [1:0] CLS_TOP   = 2'd2;

	localparam logic [1:0] KIND_OTHER  = 2'd0;
	localparam logic [1:0] KIND_LETTER = 2'd1;
	localparam logic [1:0] KIND_SPACE  = 2'd2;
	localparam logic [1:0] KIND_STOP   = 2'd3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		count_t                 letters;
		count_t                 stops;
		logic [COUNT_WIDTH:0]   words;
	} job_t;

	function automatic logic [1:0] char_kind(input logic [7:0] c);
		logic [1:0] k;
		k = KIND_OTHER;
		if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]})
			k = KIND_LETTER;
		else if (c inside {8'h20, [8'h09:8'h0D]})
			k = KIND_SPACE;
		else if (c inside {8'h2E, 8'h21, 8'h3F})
			k = KIND_STOP;
		return k;
	endfunction

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/rgc_in_if.sv */
// ----------------------------------------------------------------------------
// rgc_in_if
// Byte stream channel: one text byte and an end-of-text flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink   (input valid, char_code, last_char, output ready);
endinterface

`default_nettype wire

/* rtl/core/rgc_out_if.sv */
// ----------------------------------------------------------------------------
// rgc_out_if
// Result channel: rounded index, grade class and grade number per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgc_out_if;
	import rgc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [IDX_W-1:0] grade_index;
	logic [1:0]              grade_class;
	logic [GN_W-1:0]         grade_number;

	modport source (output valid, grade_index, grade_class, grade_number, input ready);
	modport sink   (input valid, grade_index, grade_class, grade_number, output ready);
endinterface

`default_nettype wire

/* rtl/core/rgc_front.sv */
// ----------------------------------------------------------------------------
// rgc_front
// Classifies each byte and keeps the saturating letter, space and stop
// counters; on the last byte hands the totals on as one job.
// ----------------------------------------------------------------------------
`default_nettype none

module rgc_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rgc_in_if.sink             text_in,
	input  wire logic          q_full,
	output rgc_pkg::job_t      push_job,
	output logic               push
);
	import rgc_pkg::*;

	count_t     letter_q, space_q, stop_q;
	count_t     letter_nxt, space_nxt, stop_nxt;
	logic [1:0] kind;
	logic       accept;

	assign text_in.ready = !q_full;
	assign accept        = text_in.valid && text_in.ready;
	assign push          = accept && text_in.last_char;

	always_comb begin
		kind       = char_kind(text_in.char_code);
		letter_nxt = letter_q;
		space_nxt  = space_q;
		stop_nxt   = stop_q;
		case (kind)
			KIND_LETTER: letter_nxt = sat_inc(letter_q);
			KIND_SPACE:  space_nxt  = sat_inc(space_q);
			KIND_STOP:   stop_nxt   = sat_inc(stop_q);
			default:     ;
		endcase
		push_job.letters = letter_nxt;
		push_job.stops   = stop_nxt;
		push_job.words   = {1'b0, space_nxt} + (COUNT_WIDTH+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q <= '0;
			space_q  <= '0;
			stop_q   <= '0;
		end else if (accept) begin
			if (text_in.last_char) begin
				letter_q <= '0;
				space_q  <= '0;
				stop_q   <= '0;
			end else begin
				letter_q <= letter_nxt;
				space_q  <= space_nxt;
				stop_q   <= stop_nxt;
			end
		end
	end

`ifndef ASSERT_OFF
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (letter_q == '0 && space_q == '0 && stop_q == '0))
		else $error("counters not cleared after last beat");
`endif

endmodule

`default_nettype wire

/* rtl/core/rgc_queue.sv */
// ----------------------------------------------------------------------------
// rgc_queue
// Short job queue between the counting front and the arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module rgc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rgc_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output rgc_pkg::job_t      head_job
);
	import rgc_pkg::*;

	job_t              job_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = job_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			job_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - QCNT_W'(1)))
		else $error("queue occupancy wrong after pop");
`endif

endmodule

`default_nettype wire

/* rtl/core/rgc_back.sv */
// ----------------------------------------------------------------------------
// rgc_back
// Takes a job, forms the index numerator, divides with rounding by a
// restoring radix-2 loop, grades the result and holds it for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module rgc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire rgc_pkg::job_t head_job,
	output logic               pop,
	rgc_out_if.source          grade_out
);
	import rgc_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [PROD_W-1:0] prod_l_q, prod_s_q, prod_w_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  mag;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W:0]    trial;
	logic              take;
	logic [DCNT_W-1:0] cnt_q;
	logic              neg_q;

	logic                    out_valid_q;
	logic signed [IDX_W-1:0] idx_q;
	logic [1:0]              cls_q;
	logic [GN_W-1:0]         gnum_q;

	logic signed [IDX_W-1:0] idx_d;
	logic [1:0]              cls_d;
	logic [GN_W-1:0]         gnum_d;
	logic                    out_free;

	assign pop      = (state_q == ST_IDLE) && head_valid;
	assign out_free = !out_valid_q || grade_out.ready;

	assign mag   = num_q[NUM_W-1] ? (~num_q + NUM_W'(1)) : num_q;
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign take  = (trial >= {1'b0, dvs_q});

	// quotient sits in dvd_q once the loop is done
	always_comb begin
		if (neg_q || dvd_q == '0) begin
			cls_d  = CLS_BELOW;
			gnum_d = '0;
		end else if (dvd_q < DVD_W'(GRADE_TOP)) begin
			cls_d  = CLS_NUM;
			gnum_d = dvd_q[GN_W-1:0];
		end else begin
			cls_d  = CLS_TOP;
			gnum_d = GN_W'(GRADE_TOP);
		end
		if (neg_q)
			idx_d = (dvd_q > DVD_W'(IDX_NEG)) ? IDX_W'(IDX_NEG) : -dvd_q[IDX_W-1:0];
		else
			idx_d = (dvd_q > DVD_W'(IDX_POS)) ? IDX_W'(IDX_POS) : dvd_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				prod_l_q <= PROD_W'(head_job.letters) * PROD_W'(K_LETTER);
				prod_s_q <= PROD_W'(head_job.stops) * PROD_W'(K_STOP);
				prod_w_q <= PROD_W'(head_job.words) * PROD_W'(K_WORD);
				dvs_q    <= DVS_W'(head_job.words) * DVS_W'(K_DEN2);
			end
			ST_SUM: begin
				num_q <= NUM_W'(prod_l_q) - NUM_W'(prod_s_q) - NUM_W'(prod_w_q);
			end
			ST_PREP: begin
				neg_q <= num_q[NUM_W-1];
				// 2*|num| + den, so that floor(dvd / 2den) rounds half away
				dvd_q <= {mag, 1'b0} + DVD_W'(dvs_q[DVS_W-1:1]);
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= take ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], take};
			end
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			idx_q  <= idx_d;
			cls_q  <= cls_d;
			gnum_q <= gnum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && grade_out.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head_valid)
						state_q <= ST_SUM;
				end
				ST_SUM:  state_q <= ST_PREP;
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + DCNT_W'(1);
					if (cnt_q == DCNT_W'(DVD_W-1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign grade_out.valid        = out_valid_q;
	assign grade_out.grade_index  = idx_q;
	assign grade_out.grade_class  = cls_q;
	assign grade_out.grade_number = gnum_q;

`ifndef ASSERT_OFF
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");
	a_numbered_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && cls_q == CLS_NUM) |->
		(gnum_q != '0 && gnum_q < GN_W'(GRADE_TOP)))
		else $error("numbered grade out of range");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= DCNT_W'(DVD_W-1)))
		else $error("division step count overran");
`endif

endmodule

`default_nettype wire

/* rtl/core/readability_grade_counter.sv */
// Readability grade counter (Coleman-Liau index).
// Throughput: one text byte per cycle while the queue is not full, set by the
//   counter stage; the divider starts a text only after handing on the one before.
// A finished text waits in the queue (two may wait there), then passes the
//   product, sum, prep and one-bit-a-cycle divide steps to the result register.
// Reset (arst_n low): counters, queue, divider state and result valid clear at once.
`default_nettype none

module readability_grade_counter (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rgc_in_if.sink     text_in,
	rgc_out_if.source  grade_out
);
	import rgc_pkg::*;

	job_t push_job, head_job;
	logic push, q_full, pop, head_valid;

	rgc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.q_full   (q_full),
		.push_job (push_job),
		.push     (push)
	);

	rgc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	rgc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.grade_out  (grade_out)
	);

endmodule

`default_nettype wire

/* dv/tb_readability_grade_counter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_readability_grade_counter
// Streams texts into the grade counter and checks every result beat against an
// in-bench Coleman-Liau predictor or a typed grade. A short script covers byte
// class boundaries, index one, the top grade and long single-class runs. Random
// texts follow, with random gaps on both channels and one long result hold-off.
// ----------------------------------------------------------------------------

module tb_readability_grade_counter;
	import rgc_pkg::*;

	localparam int  N_ROWS       = 30;
	localparam int  RANDOM_BYTES = 1700;
	localparam int  HOLD_CYCLES  = 400;
	localparam int  STALL_LIMIT  = 3000;
	// drain margin after the last result: divider latency plus slack
	localparam int  DRAIN_CYCLES = DVD_W + 30;

	localparam longint WT_LETTER = 588;
	localparam longint WT_STOP   = 2960;
	localparam longint WT_WORD   = 1580;
	localparam longint WT_DEN    = 100;

	typedef struct packed {
		logic signed [IDX_W-1:0] idx;
		logic [1:0]              cls;
		logic [GN_W-1:0]         num;
	} grade_t;

	typedef struct {
		logic [7:0] code;
		int         rep;
		bit         fin;
		bit         typed;
		int         idx;
		logic [1:0] cls;
		int         num;
	} text_row_t;

	logic clk;
	logic arst_n;

	rgc_in_if  text_if ();
	rgc_out_if grade_if ();

	readability_grade_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_if),
		.grade_out (grade_if)
	);

	count_t    letters, spaces, stops;
	grade_t    grades_due[$];
	grade_t    typed_grade;
	bit        typed_valid;
	bit        byte_taken;
	bit        hold_go;
	int        errors;
	int        cycle_count;
	int        stall_cycles;
	text_row_t script [N_ROWS];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// the early part of each repeating cycle_count window runs with no gaps at all
	function automatic bit take_break();
		if ((cycle_count % 8192) < 2500)
			return 1'b0;
		return $urandom_range(0, 99) < 6;
	endfunction

	function automatic grade_t coleman_liau(input longint l, input longint s, input longint w);
		longint num, den, mag, q, idx;
		grade_t g;
		num = WT_LETTER * l - WT_STOP * s - WT_WORD * w;
		den = WT_DEN * w;
		mag = (num < 0) ? -num : num;
		// halves round away from zero
		q   = (2 * mag + den) / (2 * den);
		idx = (num < 0) ? -q : q;
		if (idx < 1) begin
			g.cls = CLS_BELOW;
			g.num = '0;
		end else if (idx < GRADE_TOP) begin
			g.cls = CLS_NUM;
			g.num = idx[GN_W-1:0];
		end else begin
			g.cls = CLS_TOP;
			g.num = GN_W'(GRADE_TOP);
		end
		// class and number come from the exact index, only the field clips
		if (idx > IDX_POS)
			idx = IDX_POS;
		if (idx < -longint'(IDX_NEG))
			idx = -longint'(IDX_NEG);
		g.idx = idx[IDX_W-1:0];
		return g;
	endfunction

	task automatic tally_byte(input logic [7:0] c);
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
			if (letters != '1)
				letters = letters + count_t'(1);
		end else if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
			if (spaces != '1)
				spaces = spaces + count_t'(1);
		end else if (c == "." || c == "!" || c == "?") begin
			if (stops != '1)
				stops = stops + count_t'(1);
		end
	endtask

	task automatic check_field(input string fname, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endtask

	// acceptance on both channels, prediction, checking and the stall watchdog
	always @(posedge clk) begin : track
		grade_t g;
		bit     grade_taken;
		byte_taken  = text_if.valid && text_if.ready;
		grade_taken = grade_if.valid && grade_if.ready;
		if (byte_taken) begin
			tally_byte(text_if.char_code);
			if (text_if.last_char) begin
				g = coleman_liau(letters, stops, longint'(spaces) + 1);
				grades_due.push_back(typed_valid ? typed_grade : g);
				letters = '0;
				spaces  = '0;
				stops   = '0;
			end
		end
		if (grade_taken) begin
			if (grades_due.size() == 0) begin
				errors++;
				$display("%0t ns: result beat with none expected, actual index %0d class %0d",
					$time, grade_if.grade_index, grade_if.grade_class);
			end else begin
				g = grades_due.pop_front();
				check_field("grade_index", g.idx, grade_if.grade_index);
				check_field("grade_class", {30'd0, g.cls}, {30'd0, grade_if.grade_class});
				check_field("grade_number", {27'd0, g.num}, {27'd0, grade_if.grade_number});
			end
		end
		stall_cycles = (byte_taken || grade_taken) ? 0 : stall_cycles + 1;
		cycle_count++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL readability_grade_counter");
			$finish;
		end
	end

	// result side: random back-pressure plus one long hold-off
	initial begin : result_sink
		int  n;
		bit  hold_used;
		hold_used = 1'b0;
		grade_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++) begin
					grade_if.ready <= 1'b0;
					@(negedge clk);
				end
			end
			grade_if.ready <= !take_break();
		end
	end

	// entered and left just after a falling edge
	task automatic put_byte(input logic [7:0] code, input bit fin);
		while (take_break()) begin
			text_if.valid <= 1'b0;
			@(negedge clk);
		end
		text_if.valid     <= 1'b1;
		text_if.char_code <= code;
		text_if.last_char <= fin;
		do @(negedge clk); while (!byte_taken);
	endtask

	// mostly prose-like bytes, with a share of arbitrary ones
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
		if (r < 72)
			return 8'h20;
		if (r < 76)
			return 8'($urandom_range(9, 13));
		if (r < 84)
			case ($urandom_range(0, 2))
				0:       return ".";
				1:       return "!";
				default: return "?";
			endcase
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		int r, k, sent, len;
		arst_n            = 1'b0;
		text_if.valid     = 1'b0;
		text_if.char_code = 8'h00;
		text_if.last_char = 1'b0;
		typed_valid       = 1'b0;
		hold_go           = 1'b0;
		errors            = 0;
		cycle_count       = 0;
		stall_cycles      = 0;
		letters           = '0;
		spaces            = '0;
		stops             = '0;

		// code, repeat, last on final repeat, typed, index, class, number
		script[0]  = '{8'h00, 1, 1'b1, 1'b1, -16, CLS_BELOW, 0};
		script[1]  = '{8'hFF, 1, 1'b1, 1'b1, -16, CLS_BELOW, 0};
		script[2]  = '{".",   1, 1'b1, 1'b1, -45, CLS_BELOW, 0};
		script[3]  = '{"A",   1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[4]  = '{"Z",   1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[5]  = '{8'h40, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[6]  = '{8'h5B, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[7]  = '{"a",   1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[8]  = '{"z",   1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[9]  = '{8'h60, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[10] = '{8'h7B, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[11] = '{8'h09, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[12] = '{8'h0D, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[13] = '{8'h08, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[14] = '{8'h0E, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[15] = '{" ",   1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[16] = '{"!",   1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[17] = '{"?",   1, 1'b1, 1'b0, 0, CLS_BELOW, 0};
		// 13 letters, two sentence ends, one word: index exactly one
		script[18] = '{"k",   13, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[19] = '{".",   1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[20] = '{"!",   1, 1'b1, 1'b1, 1, CLS_NUM, 1};
		script[21] = '{"e",   6, 1'b1, 1'b1, 19, CLS_TOP, 16};
		// long runs of a single byte class
		script[22] = '{"q",   40, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[23] = '{8'h00, 1, 1'b1, 1'b0, 0, CLS_BELOW, 0};
		script[24] = '{"!",   40, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[25] = '{"?",   1, 1'b1, 1'b0, 0, CLS_BELOW, 0};
		script[26] = '{" ",   40, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[27] = '{8'h0B, 1, 1'b1, 1'b0, 0, CLS_BELOW, 0};
		script[28] = '{8'h7F, 1, 1'b0, 1'b0, 0, CLS_BELOW, 0};
		script[29] = '{8'h80, 1, 1'b1, 1'b0, 0, CLS_BELOW, 0};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < N_ROWS; r++) begin
			for (k = 0; k < script[r].rep; k++) begin
				if (k == script[r].rep - 1 && script[r].fin && script[r].typed) begin
					typed_grade.idx = script[r].idx[IDX_W-1:0];
					typed_grade.cls = script[r].cls;
					typed_grade.num = script[r].num[GN_W-1:0];
					typed_valid = 1'b1;
				end
				put_byte(script[r].code, script[r].fin && k == script[r].rep - 1);
				typed_valid = 1'b0;
			end
		end

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			if (!hold_go && sent >= RANDOM_BYTES / 2) begin
				// burst of one-byte texts while results are held back
				hold_go = 1'b1;
				for (k = 0; k < 24; k++) begin
					put_byte(pick_char(), 1'b1);
					sent++;
				end
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
			for (k = 0; k < len; k++) begin
				put_byte(pick_char(), k == len - 1);
				sent++;
			end
		end
		text_if.valid <= 1'b0;

		while (grades_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("PASS readability_grade_counter");
		else
			$display("FAIL readability_grade_counter");
		$finish;
	end

endmodule

/* readability_grade_counter.f */
rtl/core/rgc_pkg.sv
rtl/core/rgc_in_if.sv
rtl/core/rgc_out_if.sv
rtl/core/rgc_front.sv
rtl/core/rgc_queue.sv
rtl/core/rgc_back.sv
rtl/core/readability_grade_counter.sv
dv/tb_readability_grade_counter.sv
